// File: rtl/pi_speed_controller_filtered_core_assert.svh
// Assertion macros used by the checker file.
`ifndef PI_SPEED_CONTROLLER_FILTERED_CORE_ASSERT_SVH
`define PI_SPEED_CONTROLLER_FILTERED_CORE_ASSERT_SVH

// Check a property on the rising clock, ignored while reset is asserted.
`define PSCF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the rising clock at every edge.
`define PSCF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pscf_pkg.sv
`default_nettype none

package pscf_pkg;

    localparam int unsigned SPEED_W = 16;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned LIMIT_W = 23;
    localparam int unsigned ERR_W = 17;
    localparam int unsigned ERR16_W = 25;
    localparam int unsigned FILT_W = 26;
    localparam int unsigned ESUM_W = 32;
    localparam int unsigned KEEP_PROD_W = 44;
    localparam int unsigned TAKE_PROD_W = 40;
    localparam int unsigned P_PROD_W = 43;
    localparam int unsigned I_PROD_W = 49;
    localparam int unsigned SUM_W = 50;
    localparam int unsigned FRAC_OUT = 24;
    localparam int unsigned FRAC_FILT = 16;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic signed [17:0] FILT_KEEP = 18'sd55050;
    localparam logic signed [14:0] FILT_TAKE = 15'sd10486;
    localparam logic signed [FILT_W+19:0] FILT_ROUND = 46'sd32768;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd100;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd100;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd512;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 23'd25600;

    localparam logic [1:0] REG_PROP_GAIN = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_INTEG_LIMIT = 2'd2;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [SPEED_W-1:0] measured_speed;
        logic signed [SPEED_W-1:0] target_value;
    } pscf_in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } pscf_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [LIMIT_W-1:0] integ_limit;
    } pscf_cfg_t;

    typedef struct packed {
        logic load;
        logic filt;
        logic integ;
        logic prod;
        logic emit;
    } pscf_cmd_t;

endpackage

`default_nettype wire

// File: rtl/pscf_regs.sv
`default_nettype none

module pscf_regs
    import pscf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output pscf_cfg_t              cfg
);

    pscf_cfg_t cfg_reg;
    pscf_cfg_t cfg_next;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_PROP_GAIN: cfg_next.prop_gain = pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: cfg_next.integ_gain = pwdata[GAIN_W-1:0];
                REG_INTEG_LIMIT: cfg_next.integ_limit = pwdata[LIMIT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain <= PROP_GAIN_RST;
            cfg_reg.integ_gain <= INTEG_GAIN_RST;
            cfg_reg.integ_limit <= INTEG_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PROP_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.prop_gain};
            REG_INTEG_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.integ_gain};
            REG_INTEG_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_reg.integ_limit};
            default: prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pscf_ctrl.sv
`default_nettype none

module pscf_ctrl
    import pscf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic item_clear,
    output logic      m_valid,
    input  wire logic m_ready,
    output pscf_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILT  = 5'b00010,
        ST_INTEG = 5'b00100,
        ST_PROD  = 5'b01000,
        ST_OUT   = 5'b10000
    } pscf_state_t;

    pscf_state_t state_reg;
    pscf_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = (item_clear == CMD_CLEAR) ? ST_OUT : ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.filt = 1'b1;
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pscf_dpath.sv
`default_nettype none

module pscf_dpath
    import pscf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire pscf_cmd_t cmd,
    input  wire pscf_cfg_t cfg,
    input  wire pscf_in_t  in_item,
    output pscf_out_t      out_item
);

    logic signed [FILT_W-1:0]      filt_reg;
    logic signed [FILT_W-1:0]      filt_next;
    logic signed [ESUM_W-1:0]      esum_reg;
    logic signed [ESUM_W-1:0]      esum_next;
    logic signed [KEEP_PROD_W-1:0] keep_reg;
    logic signed [TAKE_PROD_W-1:0] take_reg;
    logic signed [P_PROD_W-1:0]    p_reg;
    logic signed [I_PROD_W-1:0]    i_reg;
    logic                          clr_reg;
    pscf_out_t                     out_reg;
    pscf_out_t                     out_next;

    logic signed [ERR_W-1:0]       err;
    logic signed [ERR16_W-1:0]     err16;
    logic signed [FILT_W+19:0]     filt_acc;
    logic signed [ESUM_W:0]        esum_raw;
    logic signed [ESUM_W:0]        lim_pos;
    logic signed [ESUM_W:0]        lim_neg;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-1:0]       sum_adj;
    logic signed [SUM_W-FRAC_OUT-1:0] quot;

    assign err = $signed({in_item.target_value[SPEED_W-1], in_item.target_value})
               - $signed({in_item.measured_speed[SPEED_W-1], in_item.measured_speed});
    assign err16 = $signed({err, 8'b0});

    assign filt_acc = $signed({{2{keep_reg[KEEP_PROD_W-1]}}, keep_reg})
                    + $signed({{6{take_reg[TAKE_PROD_W-1]}}, take_reg})
                    + FILT_ROUND;

    assign esum_raw = $signed({esum_reg[ESUM_W-1], esum_reg})
                    + $signed({{(ESUM_W+1-FILT_W){filt_reg[FILT_W-1]}}, filt_reg});
    assign lim_pos = $signed({2'b00, cfg.integ_limit, 8'b0});
    assign lim_neg = -lim_pos;

    always_comb begin
        filt_next = filt_reg;
        esum_next = esum_reg;
        if (cmd.load && (in_item.cmd == CMD_CLEAR)) begin
            filt_next = '0;
            esum_next = '0;
        end else if (cmd.filt) begin
            filt_next = filt_acc[FILT_W+FRAC_FILT-1:FRAC_FILT];
        end else if (cmd.integ) begin
            if (esum_raw > lim_pos) begin
                esum_next = lim_pos[ESUM_W-1:0];
            end else if (esum_raw < lim_neg) begin
                esum_next = lim_neg[ESUM_W-1:0];
            end else begin
                esum_next = esum_raw[ESUM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
            esum_reg <= '0;
        end else begin
            filt_reg <= filt_next;
            esum_reg <= esum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clr_reg <= in_item.cmd;
            keep_reg <= filt_reg * FILT_KEEP;
            take_reg <= err16 * FILT_TAKE;
        end
        if (cmd.prod) begin
            p_reg <= $signed({1'b0, cfg.prop_gain}) * filt_reg;
            i_reg <= $signed({1'b0, cfg.integ_gain}) * esum_reg;
        end
    end

    assign sum = $signed({{(SUM_W-P_PROD_W){p_reg[P_PROD_W-1]}}, p_reg})
               + $signed({{(SUM_W-I_PROD_W){i_reg[I_PROD_W-1]}}, i_reg});
    assign sum_adj = sum + (sum[SUM_W-1] ? $signed(SUM_W'((1 << FRAC_OUT) - 1)) : '0);
    assign quot = sum_adj[SUM_W-1:FRAC_OUT];

    always_comb begin
        out_next = out_reg;
        if (cmd.emit) begin
            if (clr_reg == CMD_CLEAR) begin
                out_next.drive = '0;
                out_next.saturated = 1'b0;
            end else if (quot > $signed((SUM_W-FRAC_OUT)'(DRIVE_MAX))) begin
                out_next.drive = DRIVE_MAX;
                out_next.saturated = 1'b1;
            end else if (quot < $signed((SUM_W-FRAC_OUT)'(DRIVE_MIN))) begin
                out_next.drive = DRIVE_MIN;
                out_next.saturated = 1'b1;
            end else begin
                out_next.drive = quot[DRIVE_W-1:0];
                out_next.saturated = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// File: rtl/pi_speed_controller_filtered_core.sv
// PI speed regulator with a low-pass filtered error and a clamped integral.
// Input channel (s_valid/s_ready/s_payload): one transfer per control step,
// carrying a command bit, the measured speed and the target speed (Q8.8).
// A clear command zeroes the filter and the integral and answers drive 0.
// Output channel (m_valid/m_ready/m_payload): one transfer per input item,
// with the drive (-100..100) and a flag that tells it was clipped.
// Gains and the integral limit sit behind the APB port at 0x0, 0x4, 0x8;
// write them only while no step is in flight.
// A control step runs from the input transfer to m_valid through accept
// with the error multiplies, filter update, integral update and clamp,
// gain multiplies, output rounding and saturation; a clear goes from
// accept straight to the output step. The shared state update sequence
// takes one item at a time; s_ready is high only while no item is in flight.
// A stalled receiver holds the result in the output register; the next item
// is still taken and then waits in its last step until the register frees.
// Reset clears the filter, the integral and m_valid, and loads the default
// gains (2.0 and about 0.1) and limit (100.0).
`default_nettype none

module pi_speed_controller_filtered_core
    import pscf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pscf_in_t          s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pscf_out_t              m_payload,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    pscf_cfg_t cfg;
    pscf_cmd_t cmd;

    pscf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pscf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .item_clear (s_payload.cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd)
    );

    pscf_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_item  (s_payload),
        .out_item (m_payload)
    );

endmodule

`default_nettype wire

// File: rtl/pscf_checker.sv
`default_nettype none
`include "pi_speed_controller_filtered_core_assert.svh"

module pscf_checker
    import pscf_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire pscf_in_t          s_payload,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire pscf_out_t         m_payload,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    input wire logic [DATA_W-1:0] prdata,
    input wire logic              pready
);

    `PSCF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_payload), "result changed while stalled")
    `PSCF_ASSERT(a_drive_range, aclk, aresetn, m_valid |-> (m_payload.drive <= DRIVE_MAX) && (m_payload.drive >= DRIVE_MIN), "drive out of range")
    `PSCF_ASSERT(a_sat_edge, aclk, aresetn, m_valid && m_payload.saturated |-> (m_payload.drive == DRIVE_MAX) || (m_payload.drive == DRIVE_MIN), "saturated flag without clipped drive")
    `PSCF_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second item taken while one in flight")
    `PSCF_ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready dropped")

endmodule

bind pi_speed_controller_filtered_core pscf_checker u_pscf_checker (.*);

`default_nettype wire
